[hw/rtl/bump_then_fifo_descriptor_allocator_core_assert.svh]
// Assertion macros shared by the descriptor allocator checker.
// Needs nothing but a clock and an active-low reset name at each use.
`ifndef BUMP_THEN_FIFO_DESCRIPTOR_ALLOCATOR_CORE_ASSERT_SVH
`define BUMP_THEN_FIFO_DESCRIPTOR_ALLOCATOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTFA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BTFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/btfa_pkg.sv]
// Shared types and constants of the descriptor slot allocator.
// Used by the core, the port checker and the testbench; depends on nothing.
package btfa_pkg;

    localparam int SLOT_W        = 10;
    localparam int TOTAL_W       = 11;
    localparam int STRIDE_W      = 13;
    localparam int ADDR_W        = 64;
    localparam int OFF_W         = SLOT_W + STRIDE_W;
    localparam int MAX_SLOTS_DEF = 1024;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;

    localparam logic [1:0] REG_TOTAL_SLOTS = 2'd0;
    localparam logic [1:0] REG_SLOT_STRIDE = 2'd1;
    localparam logic [1:0] REG_CPU_BASE    = 2'd2;
    localparam logic [1:0] REG_GPU_BASE    = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW  = 2'd3;

    localparam logic [TOTAL_W-1:0]  TOTAL_RST  = '0;
    localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd32;
    localparam logic [ADDR_W-1:0]   CPU_RST    = '0;
    localparam logic [ADDR_W-1:0]   GPU_RST    = '1;

    typedef struct packed {
        logic              mode;
        logic [SLOT_W-1:0] free_slot;
    } req_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] cpu_address;
        logic [ADDR_W-1:0] gpu_address;
    } rsp_item_t;

endpackage

[hw/rtl/btfa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the free-slot queue of the allocator.
module btfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/bump_then_fifo_descriptor_allocator_core.sv]
// Descriptor slot allocator: one request beat per cycle while the response side does not stall,
// each answered by one response beat. Allocates hand out never-used slots
// up to total_slots, then the oldest freed index from a MAX_SLOTS-deep queue held in one RAM;
// the RAM's registered read and the index-times-stride multiply feed the second stage.
// The queue needs no clearing pass after reset. Configure only while no request is in flight.
module bump_then_fifo_descriptor_allocator_core #(
    parameter int MAX_SLOTS = btfa_pkg::MAX_SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  btfa_pkg::req_item_t          req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output btfa_pkg::rsp_item_t          rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [btfa_pkg::PADDR_W-1:0] paddr,
    input  logic [btfa_pkg::PDATA_W-1:0] pwdata,
    output logic [btfa_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);

    import btfa_pkg::*;

    localparam int PTR_W  = $clog2(MAX_SLOTS);
    localparam int FILL_W = $clog2(MAX_SLOTS + 1);

    // Configuration registers
    logic [TOTAL_W-1:0]  total_slots_reg;
    logic [STRIDE_W-1:0] slot_stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                cfg_write;
    logic [1:0]          cfg_sel;

    // Allocator state
    logic [TOTAL_W-1:0] bump_count_reg, bump_count_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    // Pipeline
    logic              v1_reg, v2_reg, v3_reg;
    logic              r1, r2, r3;
    logic              accept, move12, move23;
    logic [1:0]        s1_status_reg, s1_status_next;
    logic              s1_pop_reg, s1_pop_next;
    logic [SLOT_W-1:0] s1_idx_reg;
    logic [1:0]        s2_status_reg;
    logic [SLOT_W-1:0] s2_idx_reg;
    logic [OFF_W-1:0]  s2_off_reg;
    rsp_item_t         rsp_reg;

    logic [TOTAL_W-1:0] limit;
    logic               total_over;
    logic               can_bump, can_pop, fifo_full;
    logic               push, pop;
    logic [SLOT_W-1:0]  ram_q;
    logic [SLOT_W-1:0]  s2_idx_in;
    logic               s3_grant;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_sel   = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_slots_reg <= TOTAL_RST;
            slot_stride_reg <= STRIDE_RST;
            cpu_base_reg    <= CPU_RST;
            gpu_base_reg    <= GPU_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_TOTAL_SLOTS: total_slots_reg <= pwdata[TOTAL_W-1:0];
                REG_SLOT_STRIDE: slot_stride_reg <= pwdata[STRIDE_W-1:0];
                REG_CPU_BASE:    cpu_base_reg    <= pwdata;
                REG_GPU_BASE:    gpu_base_reg    <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_TOTAL_SLOTS: prdata = PDATA_W'(total_slots_reg);
            REG_SLOT_STRIDE: prdata = PDATA_W'(slot_stride_reg);
            REG_CPU_BASE:    prdata = cpu_base_reg;
            REG_GPU_BASE:    prdata = gpu_base_reg;
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign r3        = !v3_reg || rsp_ready;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign req_ready = r1;
    assign accept    = req_valid & req_ready;
    assign move12    = v1_reg & r2;
    assign move23    = v2_reg & r3;

    // ---------------- decision stage ----------------
    // A total beyond the queue capacity is clamped to it.
    assign total_over = 32'(total_slots_reg) > 32'(MAX_SLOTS);
    assign limit      = total_over ? TOTAL_W'(MAX_SLOTS) : total_slots_reg;
    assign can_bump   = bump_count_reg < limit;
    assign can_pop    = fill_reg != '0;
    assign fifo_full  = fill_reg == FILL_W'(MAX_SLOTS);

    always_comb
    begin
        bump_count_next = bump_count_reg;
        push            = 1'b0;
        pop             = 1'b0;
        s1_pop_next     = 1'b0;
        s1_status_next  = ST_ALLOCATED;
        if (req.mode == MODE_ALLOC)
        begin
            if (can_bump)
            begin
                bump_count_next = bump_count_reg + 1'b1;
            end
            else if (can_pop)
            begin
                pop         = accept;
                s1_pop_next = 1'b1;
            end
            else
            begin
                s1_status_next = ST_EXHAUSTED;
            end
        end
        else if (fifo_full)
        begin
            s1_status_next = ST_OVERFLOW;
        end
        else
        begin
            push           = accept;
            s1_status_next = ST_FREED;
        end
    end

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (pop)
        begin
            head_next = (head_reg == PTR_W'(MAX_SLOTS - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(MAX_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bump_count_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
        end
        else if (accept)
        begin
            bump_count_reg <= bump_count_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
        end
    end

    // The popped index appears at the RAM output in the cycle after the accept, and holds
    // there because no further read is issued until the first stage passes its beat on.
    btfa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_free_ram (
        .clk   (clk),
        .we    (push),
        .waddr (tail_reg),
        .wdata (req.free_slot),
        .re    (pop),
        .raddr (head_reg),
        .rdata (ram_q)
    );

    // ---------------- pipeline valids ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                v1_reg <= 1'b1;
            end
            else if (r2)
            begin
                v1_reg <= 1'b0;
            end
            if (move12)
            begin
                v2_reg <= 1'b1;
            end
            else if (r3)
            begin
                v2_reg <= 1'b0;
            end
            if (move23)
            begin
                v3_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                v3_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload stages ----------------
    always_comb
    begin
        if (s1_status_reg != ST_ALLOCATED)
        begin
            s2_idx_in = '0;
        end
        else if (s1_pop_reg)
        begin
            s2_idx_in = ram_q;
        end
        else
        begin
            s2_idx_in = s1_idx_reg;
        end
    end

    assign s3_grant = s2_status_reg == ST_ALLOCATED;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= s1_status_next;
            s1_pop_reg    <= s1_pop_next;
            s1_idx_reg    <= bump_count_reg[SLOT_W-1:0];
        end
        if (move12)
        begin
            s2_status_reg <= s1_status_reg;
            s2_idx_reg    <= s2_idx_in;
            s2_off_reg    <= OFF_W'(s2_idx_in * slot_stride_reg);
        end
        if (move23)
        begin
            rsp_reg.status      <= s2_status_reg;
            rsp_reg.slot_index  <= s2_idx_reg;
            rsp_reg.cpu_address <= s3_grant ? cpu_base_reg + ADDR_W'(s2_off_reg) : '0;
            rsp_reg.gpu_address <= s3_grant ? gpu_base_reg + ADDR_W'(s2_off_reg) : '0;
        end
    end

    assign rsp_valid = v3_reg;
    assign rsp       = rsp_reg;

endmodule

[hw/rtl/btfa_checker.sv]
// Port-level checker for the descriptor slot allocator, bound to the core below.
// Depends on btfa_pkg and the assertion macro header.
`include "bump_then_fifo_descriptor_allocator_core_assert.svh"

module btfa_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input btfa_pkg::rsp_item_t rsp
);

    import btfa_pkg::*;

    localparam logic [2:0] PIPE_STAGES = 3'd3;

    logic       req_beat, rsp_beat;
    logic [2:0] pending_reg, pending_next;

    assign req_beat = req_valid & req_ready;
    assign rsp_beat = rsp_valid & rsp_ready;

    // Requests taken but not yet answered.
    always_comb
    begin
        pending_next = pending_reg;
        if (req_beat && !rsp_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!req_beat && rsp_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `BTFA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp), "response beat changed while stalled")
    `BTFA_ASSERT_SAME(a_zero_unless_granted, clk, rst_n,
        rsp_valid && (rsp.status != ST_ALLOCATED),
        (rsp.slot_index == '0) && (rsp.cpu_address == '0) && (rsp.gpu_address == '0),
        "non-grant response carries a nonzero index or address")
    `BTFA_ASSERT_SAME(a_no_invented_rsp, clk, rst_n, rsp_valid, pending_reg != '0,
        "response beat without an outstanding request")
    `BTFA_ASSERT_SAME(a_pipe_bound, clk, rst_n, 1'b1, pending_reg <= PIPE_STAGES,
        "more requests in flight than pipeline stages")

endmodule

bind bump_then_fifo_descriptor_allocator_core btfa_checker u_btfa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

[tb/tb_bump_then_fifo_descriptor_allocator_core.sv]
// Self-checking testbench for the bump-then-FIFO descriptor slot allocator core.
// Depends on btfa_pkg and the core. It predicts every response beat with its own model
// of the bump counter and the free queue, and it programs the core through its APB port.
module tb_bump_then_fifo_descriptor_allocator_core;
    import btfa_pkg::*;

    localparam int MAX_SLOTS     = MAX_SLOTS_DEF;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 200;
    localparam int RAND_TOTAL    = 2050;
    localparam logic [ADDR_W-1:0] ONES = '1;

    typedef enum logic { ROW_CFG, ROW_REQ } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic [1:0]        reg_idx;
        logic [63:0]       value;
        logic              mode;
        logic [SLOT_W-1:0] slot;
        logic              fixed;
        logic [1:0]        st;
        logic [SLOT_W-1:0] idx;
        logic [ADDR_W-1:0] cpu;
        logic [ADDR_W-1:0] gpu;
    } dir_row_t;

    localparam int DIR_ROWS = 26;

    // Rows with fixed set carry a hand-written response; the others go to the predictor.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Reset configuration: no slots, so the first allocate finds nothing left.
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b1, ST_EXHAUSTED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_FREE,  10'd1023, 1'b1, ST_FREED,     10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_FREE,  10'd0,    1'b1, ST_FREED,     10'd0,
          64'd0, 64'd0},
        // Popping the freed slots; the all-ones device base wraps around.
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd1023, 1'b1, ST_ALLOCATED, 10'd1023,
          64'd32736, 64'd32735},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b1, ST_ALLOCATED, 10'd0,
          64'd0, ONES},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b1, ST_EXHAUSTED, 10'd0,
          64'd0, 64'd0},
        // Zero stride gives the base address for every slot.
        '{ROW_CFG, REG_SLOT_STRIDE, 64'd0, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_CFG, REG_CPU_BASE, 64'hFFFF_FFFF_FFFF_FFF0, MODE_ALLOC, 10'd0, 1'b0, ST_ALLOCATED,
          10'd0, 64'd0, 64'd0},
        '{ROW_CFG, REG_TOTAL_SLOTS, 64'd2, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd512,  1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b1, ST_EXHAUSTED, 10'd0,
          64'd0, 64'd0},
        // A slot beyond the total, then the same slot again, are both queued.
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_FREE,  10'd5,    1'b1, ST_FREED,     10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_FREE,  10'd5,    1'b1, ST_FREED,     10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b1, ST_EXHAUSTED, 10'd0,
          64'd0, 64'd0},
        // A total above capacity is clamped; widest stride with wrapping bases.
        '{ROW_CFG, REG_TOTAL_SLOTS, 64'd2047, MODE_ALLOC, 10'd0, 1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_CFG, REG_SLOT_STRIDE, 64'd8191, MODE_ALLOC, 10'd0, 1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_CFG, REG_CPU_BASE, ONES, MODE_ALLOC, 10'd0,        1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_CFG, REG_GPU_BASE, 64'd0, MODE_ALLOC, 10'd0,       1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_FREE,  10'h2AA,  1'b1, ST_FREED,     10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_FREE,  10'h155,  1'b1, ST_FREED,     10'd0,
          64'd0, 64'd0},
        '{ROW_REQ, REG_TOTAL_SLOTS, 64'd0, MODE_ALLOC, 10'h3FF,  1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0},
        '{ROW_CFG, REG_SLOT_STRIDE, 64'd1, MODE_ALLOC, 10'd0,    1'b0, ST_ALLOCATED, 10'd0,
          64'd0, 64'd0}
    };

    logic                clk;
    logic                rst_n;
    logic                req_valid;
    logic                req_ready;
    req_item_t           req;
    logic                rsp_valid;
    logic                rsp_ready;
    rsp_item_t           rsp;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Local copy of the allocator state and its registers.
    logic [TOTAL_W-1:0]  cfg_total;
    logic [STRIDE_W-1:0] cfg_stride;
    logic [ADDR_W-1:0]   cfg_cpu_base;
    logic [ADDR_W-1:0]   cfg_gpu_base;
    logic [TOTAL_W-1:0]  bump_count;
    logic [SLOT_W-1:0]   freed_slots [$];
    logic [SLOT_W-1:0]   held_slots [$];

    rsp_item_t           due_responses [$];
    int                  err_count;
    int                  cycle_count;
    int                  src_idle_pct;
    int                  snk_idle_pct;
    int                  hold_left;

    bump_then_fifo_descriptor_allocator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic rsp_item_t allocate_or_free(req_item_t r);
        rsp_item_t          o;
        logic [TOTAL_W-1:0] lim;
        logic [SLOT_W-1:0]  idx;
        logic [ADDR_W-1:0]  off;
        logic               granted;
        o = '0;
        granted = 1'b0;
        idx = '0;
        if (r.mode == MODE_ALLOC)
        begin
            lim = (cfg_total > MAX_SLOTS) ? TOTAL_W'(MAX_SLOTS) : cfg_total;
            if (bump_count < lim)
            begin
                idx = bump_count[SLOT_W-1:0];
                bump_count = bump_count + 1'b1;
                granted = 1'b1;
            end
            else if (freed_slots.size() > 0)
            begin
                idx = freed_slots.pop_front();
                granted = 1'b1;
            end
            else
                o.status = ST_EXHAUSTED;
            if (granted)
            begin
                off = 64'(idx) * 64'(cfg_stride);
                o.status = ST_ALLOCATED;
                o.slot_index = idx;
                o.cpu_address = cfg_cpu_base + off;
                o.gpu_address = cfg_gpu_base + off;
                held_slots.push_back(idx);
            end
        end
        else if (freed_slots.size() >= MAX_SLOTS)
            o.status = ST_OVERFLOW;
        else
        begin
            freed_slots.push_back(r.free_slot);
            o.status = ST_FREED;
        end
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Offers one request beat and records its expected response once it is accepted.
    task automatic send_request(input req_item_t item, input logic fixed,
                                input rsp_item_t fixed_rsp);
        rsp_item_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (!req_ready);
        predicted = allocate_or_free(item);
        due_responses.push_back(fixed ? fixed_rsp : predicted);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TOTAL_SLOTS: cfg_total = val[TOTAL_W-1:0];
            REG_SLOT_STRIDE: cfg_stride = val[STRIDE_W-1:0];
            REG_CPU_BASE:    cfg_cpu_base = val;
            default:         cfg_gpu_base = val;
        endcase
    endtask

    // Waits for every outstanding response, then, with slack, lets the pipeline go quiet.
    task automatic settle(input logic with_slack);
        req_valid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
        if (with_slack)
            repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Response side: checks each accepted beat and decides ready for the next cycle.
    initial
    begin
        rsp_item_t want;
        rsp_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (rsp_valid && rsp_ready)
                begin
                    if (due_responses.size() == 0)
                        report_mismatch("unexpected response beat", rsp.status, 0);
                    else
                    begin
                        want = due_responses.pop_front();
                        if (rsp.status != want.status)
                            report_mismatch("status", rsp.status, want.status);
                        if (rsp.slot_index != want.slot_index)
                            report_mismatch("slot_index", rsp.slot_index, want.slot_index);
                        if (rsp.cpu_address != want.cpu_address)
                            report_mismatch("cpu_address", rsp.cpu_address, want.cpu_address);
                        if (rsp.gpu_address != want.gpu_address)
                            report_mismatch("gpu_address", rsp.gpu_address, want.gpu_address);
                    end
                end
                if (hold_left > 0)
                begin
                    rsp_ready <= 1'b0;
                    hold_left--;
                end
                else
                    rsp_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bump_then_fifo_descriptor_allocator_core regression: fail");
        $finish;
    end

    initial
    begin
        req_item_t   item;
        rsp_item_t   fixed_rsp;
        dir_row_t    row;
        int          rand_sent;
        int          items;
        int          free_pct;
        int          k;
        logic [63:0] v_total;
        logic [63:0] v_stride;
        logic [63:0] v_cpu;
        logic [63:0] v_gpu;

        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        err_count = 0;
        hold_left = 0;
        src_idle_pct = 23;
        snk_idle_pct = 78;
        cfg_total = TOTAL_RST;
        cfg_stride = STRIDE_RST;
        cfg_cpu_base = CPU_RST;
        cfg_gpu_base = GPU_RST;
        bump_count = '0;
        rand_sent = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
            begin
                settle(1'b1);
                write_register(row.reg_idx, row.value);
            end
            else
            begin
                item.mode = row.mode;
                item.free_slot = row.slot;
                fixed_rsp.status = row.st;
                fixed_rsp.slot_index = row.idx;
                fixed_rsp.cpu_address = row.cpu;
                fixed_rsp.gpu_address = row.gpu;
                send_request(item, row.fixed, fixed_rsp);
            end
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    v_total = 64'd1024;
                    v_stride = 64'($urandom_range(1, 4096));
                    v_cpu = {$urandom, $urandom};
                    v_gpu = {$urandom, $urandom};
                    items = 300;
                    free_pct = 35;
                end
                1:
                begin
                    v_total = 64'd2047;
                    v_stride = 64'd4096;
                    v_cpu = ONES;
                    v_gpu = ONES;
                    items = 300;
                    free_pct = 30;
                end
                2:
                begin
                    // Mostly frees, so the free queue fills and overflows.
                    v_total = 64'd512;
                    v_stride = 64'($urandom_range(0, 8191));
                    v_cpu = {$urandom, $urandom};
                    v_gpu = 64'd0;
                    items = 1150;
                    free_pct = 97;
                end
                default:
                begin
                    v_total = 64'd0;
                    v_stride = 64'($urandom_range(0, 8191));
                    v_cpu = 64'd0;
                    v_gpu = {$urandom, $urandom};
                    items = 300;
                    free_pct = 20;
                end
            endcase
            settle(1'b1);
            write_register(REG_TOTAL_SLOTS, v_total);
            write_register(REG_SLOT_STRIDE, v_stride);
            write_register(REG_CPU_BASE, v_cpu);
            write_register(REG_GPU_BASE, v_gpu);
            // The response side stalls for a long stretch while requests keep coming.
            if (ph == 1)
                hold_left = LONG_HOLD;
            for (int n = 0; n < items; n++)
            begin
                if (rand_sent < RAND_TOTAL / 3)
                begin
                    src_idle_pct = 23;
                    snk_idle_pct = 78;
                end
                else if (rand_sent < 2 * RAND_TOTAL / 3)
                begin
                    src_idle_pct = 78;
                    snk_idle_pct = 23;
                end
                else
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                if (ph == 0 && n == 150)
                    settle(1'b0);
                item.free_slot = SLOT_W'($urandom_range(0, 1023));
                if ($urandom_range(0, 99) < free_pct)
                begin
                    item.mode = MODE_FREE;
                    // Half of the frees hand back a slot that is actually held.
                    if (held_slots.size() > 0 && $urandom_range(0, 1) == 1)
                    begin
                        k = $urandom_range(0, held_slots.size() - 1);
                        item.free_slot = held_slots[k];
                        held_slots.delete(k);
                    end
                end
                else
                    item.mode = MODE_ALLOC;
                send_request(item, 1'b0, '0);
                rand_sent++;
            end
        end

        settle(1'b1);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("bump_then_fifo_descriptor_allocator_core regression: pass");
        else
            $display("bump_then_fifo_descriptor_allocator_core regression: fail");
        $finish;
    end

endmodule
